/* src/mrw_pkg.sv */
// Shared types and constants for the micropacket router with watchdog.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package mrw_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // Micropacket parser phase
  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PIPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // Fault codes reported on the result channel
  typedef enum logic [1:0] {
    FAULT_BAD_LENGTH = 2'd0,
    FAULT_NO_PIPE    = 2'd1,
    FAULT_OVERFLOW   = 2'd2
  } fault_e;

  // Configuration register indexes
  localparam logic CFG_DRIVE_PIPE = 1'b0;
  localparam logic CFG_TIMEOUT    = 1'b1;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned PLEN_W   = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned OFFSET_W = 6;
  localparam int unsigned WD_W     = 8;

  // Reset value of the watchdog reload register
  localparam logic [WD_W-1:0] TIMEOUT_RESET = 8'd23;

  // Smallest legal micropacket length (length byte plus pipe byte)
  localparam logic [BYTE_W-1:0] MIN_MICRO_LEN = 8'd2;

  // Parser result for one request
  typedef struct packed {
    logic                write_valid;
    logic [NIB_W-1:0]    robot;
    logic [OFFSET_W-1:0] offset;
    logic [BYTE_W-1:0]   value;
    logic                fault_valid;
    fault_e              fault_code;
  } parse_res_t;

endpackage

/* src/mrw_parser.sv */
// Micropacket parser: splits packet bytes into micropackets, emits drive writes
// and faults. Depends on mrw_pkg.
`timescale 1ns / 1ps

module mrw_parser #(
  parameter int unsigned DRIVE_BLOCK_BYTES = 8,
  parameter int unsigned PACKET_BYTES      = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [mrw_pkg::OP_W-1:0]      op_i,
  input  logic [mrw_pkg::PLEN_W-1:0]    plen_i,
  input  logic [mrw_pkg::BYTE_W-1:0]    byte_i,
  input  logic [mrw_pkg::NIB_W-1:0]     drive_pipe_i,
  output mrw_pkg::parse_res_t           res_o
);

  localparam logic [mrw_pkg::PLEN_W-1:0] PKT_MAX = mrw_pkg::PLEN_W'(PACKET_BYTES);
  localparam logic [mrw_pkg::PLEN_W-1:0] DRV_LEN = mrw_pkg::PLEN_W'(DRIVE_BLOCK_BYTES);

  mrw_pkg::phase_e                  phase_q, phase_d;
  logic [mrw_pkg::PLEN_W-1:0]       pkt_left_q, pkt_left_d;
  logic [mrw_pkg::PLEN_W-1:0]       micro_q, micro_d;
  logic                             skip_q, skip_d;
  logic [mrw_pkg::NIB_W-1:0]        robot_q, robot_d;
  logic [mrw_pkg::OFFSET_W-1:0]     offset_q, offset_d;
  logic                             stopped_q, stopped_d;

  mrw_pkg::op_e                     op;
  logic                             active;
  logic [mrw_pkg::PLEN_W-1:0]       micro_dec;
  logic                             len_over;
  logic                             len_short;
  logic                             pipe_hit;

  assign op        = mrw_pkg::op_e'(op_i);
  assign active    = !stopped_q && (pkt_left_q != '0);
  assign micro_dec = micro_q - 1'b1;
  assign len_over  = byte_i > {1'b0, pkt_left_q};
  assign len_short = byte_i < mrw_pkg::MIN_MICRO_LEN;
  assign pipe_hit  = byte_i[mrw_pkg::NIB_W-1:0] == drive_pipe_i;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (op)
        mrw_pkg::OP_START: phase_d = mrw_pkg::PH_LENGTH;
        mrw_pkg::OP_BYTE: begin
          if (active) begin
            unique case (phase_q)
              mrw_pkg::PH_LENGTH: begin
                if (!len_over && !len_short) phase_d = mrw_pkg::PH_PIPE;
              end
              mrw_pkg::PH_PIPE: begin
                phase_d = (micro_dec == '0) ? mrw_pkg::PH_LENGTH : mrw_pkg::PH_PAYLOAD;
              end
              mrw_pkg::PH_PAYLOAD: begin
                if (micro_dec == '0) phase_d = mrw_pkg::PH_LENGTH;
              end
              default: phase_d = mrw_pkg::PH_LENGTH;
            endcase
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Datapath registers and result
  always_comb begin
    pkt_left_d = pkt_left_q;
    micro_d    = micro_q;
    skip_d     = skip_q;
    robot_d    = robot_q;
    offset_d   = offset_q;
    stopped_d  = stopped_q;
    res_o      = '0;
    if (step_i) begin
      unique case (op)
        mrw_pkg::OP_START: begin
          pkt_left_d = (plen_i > PKT_MAX) ? PKT_MAX : plen_i;
          micro_d    = '0;
          skip_d     = 1'b0;
          offset_d   = '0;
          stopped_d  = 1'b0;
        end
        mrw_pkg::OP_BYTE: begin
          if (active) begin
            pkt_left_d = pkt_left_q - 1'b1;
            unique case (phase_q)
              mrw_pkg::PH_LENGTH: begin
                if (len_over) begin
                  res_o.fault_valid = 1'b1;
                  res_o.fault_code  = mrw_pkg::FAULT_OVERFLOW;
                  stopped_d         = 1'b1;
                end else if (len_short) begin
                  res_o.fault_valid = 1'b1;
                  res_o.fault_code  = mrw_pkg::FAULT_BAD_LENGTH;
                  stopped_d         = 1'b1;
                end else begin
                  micro_d = mrw_pkg::PLEN_W'(byte_i - 8'd1);
                end
              end
              mrw_pkg::PH_PIPE: begin
                micro_d = micro_dec;
                if (pipe_hit && (micro_dec == DRV_LEN)) begin
                  skip_d   = 1'b0;
                  robot_d  = byte_i[mrw_pkg::BYTE_W-1:mrw_pkg::NIB_W];
                  offset_d = '0;
                end else begin
                  skip_d            = 1'b1;
                  res_o.fault_valid = 1'b1;
                  res_o.fault_code  = pipe_hit ? mrw_pkg::FAULT_BAD_LENGTH
                                               : mrw_pkg::FAULT_NO_PIPE;
                end
              end
              mrw_pkg::PH_PAYLOAD: begin
                micro_d = micro_dec;
                if (!skip_q) begin
                  res_o.write_valid = 1'b1;
                  res_o.robot       = robot_q;
                  res_o.offset      = offset_q;
                  res_o.value       = byte_i;
                  offset_d          = offset_q + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mrw_pkg::PH_LENGTH;
      pkt_left_q <= '0;
      micro_q    <= '0;
      skip_q     <= 1'b0;
      robot_q    <= '0;
      offset_q   <= '0;
      stopped_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pkt_left_q <= pkt_left_d;
      micro_q    <= micro_d;
      skip_q     <= skip_d;
      robot_q    <= robot_d;
      offset_q   <= offset_d;
      stopped_q  <= stopped_d;
    end
  end

endmodule

/* src/micropacket_router_with_watchdog_core.sv */
// Top level of the micropacket router with watchdog: input and result
// registers, configuration, watchdog. Depends on mrw_pkg and mrw_parser.
`timescale 1ns / 1ps

// Usage
//   Request channel: in_valid_i / in_stall_o carry one request (op, packet
//   length, data byte). op 0 starts a packet, op 1 hands over one packet
//   byte, op 2 is a watchdog tick, op 3 is ignored.
//   Result channel: out_valid_o / out_stall_i carry exactly one result per
//   request: a drive-block write, a micropacket fault, or scram on a tick
//   that finds the watchdog empty; otherwise all fields are zero.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 drive pipe, 1 watchdog timeout); write only while the block is idle.
// Timing
//   A request lands in the input register, then the parser and watchdog
//   update their state and the result register is loaded. One request per
//   cycle is sustained while the result side is not stalled; each request
//   touches only a few small counters in a single pass.
// Reset and stall
//   After reset the watchdog is empty, so every tick reports scram until the
//   first packet start. A stalled result holds; the input register takes
//   one more request if empty, then in_stall_o rises until the stall ends.

module micropacket_router_with_watchdog_core #(
  parameter int unsigned DRIVE_BLOCK_BYTES = 8,
  parameter int unsigned PACKET_BYTES      = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mrw_pkg::OP_W-1:0]          in_op_i,
  input  logic [mrw_pkg::PLEN_W-1:0]        in_packet_length_i,
  input  logic [mrw_pkg::BYTE_W-1:0]        in_data_byte_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              out_write_valid_o,
  output logic [mrw_pkg::NIB_W-1:0]         out_robot_o,
  output logic [mrw_pkg::OFFSET_W-1:0]      out_offset_o,
  output logic [mrw_pkg::BYTE_W-1:0]        out_value_o,
  output logic                              out_fault_valid_o,
  output logic [1:0]                        out_fault_code_o,
  output logic                              out_scram_o,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [mrw_pkg::WD_W-1:0]          cfg_wdata_i
);

  logic                           s1_vld_q;
  logic [mrw_pkg::OP_W-1:0]       s1_op_q;
  logic [mrw_pkg::PLEN_W-1:0]     s1_plen_q;
  logic [mrw_pkg::BYTE_W-1:0]     s1_byte_q;

  logic                           out_vld_q;
  mrw_pkg::parse_res_t            out_res_q;
  logic                           out_scram_q;

  logic [mrw_pkg::NIB_W-1:0]      drive_pipe_q;
  logic [mrw_pkg::WD_W-1:0]       timeout_q;
  logic [mrw_pkg::WD_W-1:0]       wd_q, wd_d;

  logic                           out_free;
  logic                           s1_free;
  logic                           step;
  logic                           scram;
  mrw_pkg::parse_res_t            res;

  // Flow control
  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = s1_vld_q && out_free;
  assign s1_free    = !s1_vld_q || out_free;
  assign in_stall_o = !s1_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_free) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_op_q   <= in_op_i;
      s1_plen_q <= in_packet_length_i;
      s1_byte_q <= in_data_byte_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_pipe_q <= '0;
      timeout_q    <= mrw_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mrw_pkg::CFG_DRIVE_PIPE: drive_pipe_q <= cfg_wdata_i[mrw_pkg::NIB_W-1:0];
        mrw_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Micropacket parser
  mrw_parser #(
    .DRIVE_BLOCK_BYTES (DRIVE_BLOCK_BYTES),
    .PACKET_BYTES      (PACKET_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .op_i         (s1_op_q),
    .plen_i       (s1_plen_q),
    .byte_i       (s1_byte_q),
    .drive_pipe_i (drive_pipe_q),
    .res_o        (res)
  );

  // Watchdog: reload on packet start, count down on tick, scram when empty
  always_comb begin
    wd_d  = wd_q;
    scram = 1'b0;
    if (step) begin
      unique case (mrw_pkg::op_e'(s1_op_q))
        mrw_pkg::OP_START: wd_d = timeout_q;
        mrw_pkg::OP_TICK: begin
          if (wd_q != '0) wd_d = wd_q - 1'b1;
          else            scram = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_q <= '0;
    end else begin
      wd_q <= wd_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q   <= res;
      out_scram_q <= scram;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign out_write_valid_o = out_res_q.write_valid;
  assign out_robot_o       = out_res_q.robot;
  assign out_offset_o      = out_res_q.offset;
  assign out_value_o       = out_res_q.value;
  assign out_fault_valid_o = out_res_q.fault_valid;
  assign out_fault_code_o  = out_res_q.fault_code;
  assign out_scram_o       = out_scram_q;

endmodule

/* src/mrw_checker.sv */
// Port-level checks for the micropacket router with watchdog, bound to the
// top level. Depends on micropacket_router_with_watchdog_core and mrw_pkg.
`timescale 1ns / 1ps

module mrw_checker #(
  parameter int unsigned DRIVE_BLOCK_BYTES = 8
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              out_write_valid_o,
  input logic [mrw_pkg::NIB_W-1:0]         out_robot_o,
  input logic [mrw_pkg::OFFSET_W-1:0]      out_offset_o,
  input logic [mrw_pkg::BYTE_W-1:0]        out_value_o,
  input logic                              out_fault_valid_o,
  input logic [1:0]                        out_fault_code_o,
  input logic                              out_scram_o
);

  localparam logic [mrw_pkg::OFFSET_W:0] DRV_LEN = (mrw_pkg::OFFSET_W + 1)'(DRIVE_BLOCK_BYTES);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_write_valid_o)
      && $stable(out_robot_o) && $stable(out_offset_o) && $stable(out_value_o)
      && $stable(out_fault_valid_o) && $stable(out_fault_code_o)
      && $stable(out_scram_o))
    else $error("result changed while stalled");

  // A request yields at most one kind of event
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_write_valid_o, out_fault_valid_o, out_scram_o}) <= 1)
    else $error("more than one event in one result");

  // Write fields are zero unless a write is reported
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_write_valid_o |->
      out_robot_o == '0 && out_offset_o == '0 && out_value_o == '0)
    else $error("stray write fields");

  // Writes stay inside the drive block
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_write_valid_o |-> {1'b0, out_offset_o} < DRV_LEN)
    else $error("drive write past end of block");

  // The input only stalls behind a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the result side free");

endmodule

bind micropacket_router_with_watchdog_core mrw_checker #(
  .DRIVE_BLOCK_BYTES (DRIVE_BLOCK_BYTES)
) u_mrw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .out_write_valid_o (out_write_valid_o),
  .out_robot_o       (out_robot_o),
  .out_offset_o      (out_offset_o),
  .out_value_o       (out_value_o),
  .out_fault_valid_o (out_fault_valid_o),
  .out_fault_code_o  (out_fault_code_o),
  .out_scram_o       (out_scram_o)
);
